// ----- rtl/core/sww_pkg.sv -----
// Shared types, constants and register codes of the stopwatch with lap split.
package sww_pkg;

   // Timing constants
   localparam int TICKS_PER_SECOND = 100;
   localparam int COUNT_WIDTH      = 32;
   localparam int PHASE_W          = $clog2(TICKS_PER_SECOND);
   localparam int HOLD_W           = 16;
   localparam int BLINK_W          = 7;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int CMP_W            = (PHASE_W > BLINK_W) ? PHASE_W : BLINK_W;

   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SECOND - 1);
   localparam logic [5:0]         SEC_LAST   = 6'd59;
   localparam logic [5:0]         MIN_LAST   = 6'd59;
   localparam logic [4:0]         HOUR_LAST  = 5'd23;

   // Mode codes
   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_RUNNING = 2'd1;
   localparam logic [1:0] MODE_LAP     = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LAP_HOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BLINK    = CSR_IDX_W'(1);

   // Register reset values
   localparam logic [HOLD_W-1:0]  LAP_HOLD_RESET = HOLD_W'(500);
   localparam logic [BLINK_W-1:0] BLINK_RESET    = BLINK_W'(50);

   typedef struct packed {
      logic tick;
      logic start_button;
      logic lap_button;
   } req_item_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       red_led;
      logic       green_led;
      logic [5:0] shown_minutes;
      logic [5:0] shown_seconds;
      logic       colon_on;
      logic       console_valid;
      logic [4:0] run_hours;
      logic [5:0] run_minutes;
      logic [5:0] run_seconds;
   } rsp_item_type;

   // Counter commands from the mode logic
   typedef struct packed {
      logic clear;
      logic capture;
      logic inc;
   } count_ctl_type;

   // Next counter state, seen by the mode logic and the result formatting
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [COUNT_WIDTH-1:0] lap;
      logic [PHASE_W-1:0]     phase;
      logic [5:0]             sec;
      logic [5:0]             min;
      logic [4:0]             hour;
      logic [5:0]             lap_sec;
      logic [5:0]             lap_min;
   } count_state_type;

endpackage

// ----- rtl/core/sww_mode.sv -----
// Mode state machine, button edge detection and lap hold timeout.
module sww_mode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  sww_pkg::req_item_type       item,
   input  logic [sww_pkg::HOLD_W-1:0]  lap_hold_ticks,
   input  sww_pkg::count_state_type    cnt_next,
   output sww_pkg::count_ctl_type      ctl,
   output logic [1:0]                  mode_next
);
   import sww_pkg::*;

   logic [1:0]             mode_ff;
   logic                   start_prev_ff;
   logic                   lap_prev_ff;
   logic [1:0]             mode_s;
   logic [1:0]             mode_l;
   logic                   start_press;
   logic                   lap_press;
   logic [COUNT_WIDTH-1:0] since_lap;

   assign start_press = item.start_button & ~start_prev_ff;
   assign lap_press   = item.lap_button & ~lap_prev_ff;
   assign since_lap   = cnt_next.count - cnt_next.lap;

   // Apply start, then lap, then tick
   always_comb begin
      ctl    = '0;
      mode_s = mode_ff;
      if (start_press) begin
         case (mode_ff)
            MODE_STOPPED: mode_s = MODE_RUNNING;
            MODE_RUNNING,
            MODE_LAP:     mode_s = MODE_STOPPED;
            default:      mode_s = mode_ff;
         endcase
      end
      mode_l = mode_s;
      if (lap_press) begin
         case (mode_s)
            MODE_STOPPED: ctl.clear = 1'b1;
            MODE_RUNNING: begin
               ctl.capture = 1'b1;
               mode_l      = MODE_LAP;
            end
            MODE_LAP:     mode_l = MODE_RUNNING;
            default:      mode_l = mode_s;
         endcase
      end
      ctl.inc = item.tick && (mode_l != MODE_STOPPED);
   end

   // End lap hold once enough ticks have passed
   always_comb begin
      mode_next = mode_l;
      if (item.tick && (mode_l == MODE_LAP) && (since_lap > COUNT_WIDTH'(lap_hold_ticks))) begin
         mode_next = MODE_RUNNING;
      end
   end

   // Advance state once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STOPPED;
         start_prev_ff <= 1'b0;
         lap_prev_ff   <= 1'b0;
      end else if (step) begin
         mode_ff       <= mode_next;
         start_prev_ff <= item.start_button;
         lap_prev_ff   <= item.lap_button;
      end
   end

endmodule

// ----- rtl/core/sww_count.sv -----
// Tick counter with running second, minute and hour digits and lap snapshot.
module sww_count (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  sww_pkg::count_ctl_type    ctl,
   output sww_pkg::count_state_type  cnt_next
);
   import sww_pkg::*;

   count_state_type cnt_ff;
   count_state_type base;

   always_comb begin
      // Clear or capture ahead of the tick
      base = cnt_ff;
      if (ctl.clear) begin
         base.count = '0;
         base.phase = '0;
         base.sec   = '0;
         base.min   = '0;
         base.hour  = '0;
      end
      if (ctl.capture) begin
         base.lap     = cnt_ff.count;
         base.lap_sec = cnt_ff.sec;
         base.lap_min = cnt_ff.min;
      end
      cnt_next = base;
      // Count one tick, carrying through the digits; a counter wrap zeroes the count and all running digits
      if (ctl.inc) begin
         if (&base.count) begin
            cnt_next.count = '0;
            cnt_next.phase = '0;
            cnt_next.sec   = '0;
            cnt_next.min   = '0;
            cnt_next.hour  = '0;
         end else begin
            cnt_next.count = base.count + COUNT_WIDTH'(1);
            if (base.phase == PHASE_LAST) begin
               cnt_next.phase = '0;
               if (base.sec == SEC_LAST) begin
                  cnt_next.sec = '0;
                  if (base.min == MIN_LAST) begin
                     cnt_next.min  = '0;
                     cnt_next.hour = (base.hour == HOUR_LAST) ? 5'd0 : base.hour + 5'd1;
                  end else begin
                     cnt_next.min = base.min + 6'd1;
                  end
               end else begin
                  cnt_next.sec = base.sec + 6'd1;
               end
            end else begin
               cnt_next.phase = base.phase + PHASE_W'(1);
            end
         end
      end
   end

   // Hold state between items
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_next;
      end
   end

endmodule

// ----- rtl/core/stopwatch_with_lap.sv -----
// Top level of the stopwatch with lap split: handshake stages, registers, result format.
//
// Input channel req_*: each item carries a tick flag and the start and lap
// button levels. Result channel rsp_*: one result item per input item, in
// order, giving the mode, LED levels, displayed time and console time.
// Configuration port csr_*: index 0 sets the lap hold length in ticks,
// index 1 the blink half period; other indexes are ignored. Write only
// while the block is idle.
// An accepted item lands in the input register, and its result is loaded
// into the result register once that register is empty or being read,
// raising rsp_valid. Throughput: one item per cycle while rsp_ready is
// high; the state update is a single pass of edge detection, mode decode
// and an incremental counter with separate second, minute and hour digits.
// Reset (synchronous, active high) stops the watch, zeroes count and lap,
// empties both stages and loads the register defaults.
// When the receiver stalls, the result holds and the input register still
// takes one more item; after that req_ready drops until rsp_ready returns.
module stopwatch_with_lap (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sww_pkg::req_item_type             req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sww_pkg::rsp_item_type             rsp_item,
   input  logic                              csr_wr_en,
   input  logic [sww_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sww_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sww_pkg::*;

   logic               in_valid_ff;
   req_item_type       in_item_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;
   rsp_item_type       rsp_item_in;
   logic [HOLD_W-1:0]  lap_hold_ff;
   logic [BLINK_W-1:0] blink_ff;
   logic               advance;
   count_ctl_type      ctl;
   count_state_type    cnt_next;
   logic [1:0]         mode_next;
   logic               colon;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lap_hold_ff <= LAP_HOLD_RESET;
         blink_ff    <= BLINK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LAP_HOLD: lap_hold_ff <= csr_wdata[HOLD_W-1:0];
            REG_BLINK:    blink_ff    <= csr_wdata[BLINK_W-1:0];
            default:      ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   sww_mode u_mode (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .lap_hold_ticks (lap_hold_ff),
      .cnt_next       (cnt_next),
      .ctl            (ctl),
      .mode_next      (mode_next)
   );

   sww_count u_count (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .ctl      (ctl),
      .cnt_next (cnt_next)
   );

   assign colon = CMP_W'(cnt_next.phase) < CMP_W'(blink_ff);

   // Format the result from the updated state
   always_comb begin
      rsp_item_in               = '0;
      rsp_item_in.mode          = mode_next;
      rsp_item_in.colon_on      = colon;
      rsp_item_in.shown_minutes = cnt_next.min;
      rsp_item_in.shown_seconds = cnt_next.sec;
      case (mode_next)
         MODE_STOPPED: rsp_item_in.red_led = 1'b1;
         MODE_RUNNING: rsp_item_in.green_led = 1'b1;
         MODE_LAP: begin
            rsp_item_in.red_led       = 1'b1;
            rsp_item_in.green_led     = !colon;
            rsp_item_in.shown_minutes = cnt_next.lap_min;
            rsp_item_in.shown_seconds = cnt_next.lap_sec;
         end
         default: ;
      endcase
      if (mode_next != MODE_STOPPED) begin
         rsp_item_in.console_valid = 1'b1;
         rsp_item_in.run_hours     = cnt_next.hour;
         rsp_item_in.run_minutes   = cnt_next.min;
         rsp_item_in.run_seconds   = cnt_next.sec;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

// ----- dv/lap_watch_monitor.sv -----
`timescale 1ns / 100ps
// Result monitor: predicts every stopwatch result item and compares it with the block's output.
module lap_watch_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  sww_pkg::req_item_type          req_item,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  sww_pkg::rsp_item_type          rsp_item,
   input  logic                           csr_wr_en,
   input  logic [sww_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sww_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import sww_pkg::*;

   localparam int SECS_PER_MIN  = 60;
   localparam int SECS_PER_HOUR = 3600;
   localparam int DAY_HOURS     = 24;

   // Predicted watch state and register copies
   logic [1:0]             watch_mode;
   logic [COUNT_WIDTH-1:0] tick_total;
   logic [COUNT_WIDTH-1:0] lap_snap;
   logic                   start_seen;
   logic                   lap_seen;
   logic [HOLD_W-1:0]      hold_limit;
   logic [BLINK_W-1:0]     blink_half;

   rsp_item_type expected_readings[$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   // Apply one input item to the predicted watch and return the reading it causes
   function automatic rsp_item_type advance_watch(req_item_type it);
      rsp_item_type           res;
      logic [COUNT_WIDTH-1:0] phase;
      logic [COUNT_WIDTH-1:0] shown;
      logic [COUNT_WIDTH-1:0] secs;
      logic                   colon;

      // start button acts first, on its rising edge
      if (it.start_button && !start_seen) begin
         case (watch_mode)
            MODE_STOPPED:           watch_mode = MODE_RUNNING;
            MODE_RUNNING, MODE_LAP: watch_mode = MODE_STOPPED;
            default: ;
         endcase
      end
      start_seen = it.start_button;

      // lap button sees the mode that the start button left
      if (it.lap_button && !lap_seen) begin
         case (watch_mode)
            MODE_STOPPED: tick_total = '0;
            MODE_RUNNING: begin
               lap_snap   = tick_total;
               watch_mode = MODE_LAP;
            end
            MODE_LAP:     watch_mode = MODE_RUNNING;
            default: ;
         endcase
      end
      lap_seen = it.lap_button;

      // tick last; lap hold timeout only after the increment
      if (it.tick) begin
         if (watch_mode != MODE_STOPPED)
            tick_total = tick_total + 1'b1;
         if (watch_mode == MODE_LAP && (tick_total - lap_snap) > hold_limit)
            watch_mode = MODE_RUNNING;
      end

      phase = tick_total % TICKS_PER_SECOND;
      colon = (phase < blink_half);

      res          = '0;
      res.mode     = watch_mode;
      res.colon_on = colon;
      case (watch_mode)
         MODE_STOPPED: res.red_led = 1'b1;
         MODE_RUNNING: res.green_led = 1'b1;
         MODE_LAP: begin
            res.red_led   = 1'b1;
            res.green_led = !colon;
         end
         default: ;
      endcase

      // display shows the lap snapshot while held
      shown = ((watch_mode == MODE_LAP) ? lap_snap : tick_total) / TICKS_PER_SECOND;
      res.shown_minutes = 6'((shown / SECS_PER_MIN) % SECS_PER_MIN);
      res.shown_seconds = 6'(shown % SECS_PER_MIN);

      // console fields stay zero while stopped
      if (watch_mode != MODE_STOPPED) begin
         secs              = tick_total / TICKS_PER_SECOND;
         res.console_valid = 1'b1;
         res.run_hours     = 5'((secs / SECS_PER_HOUR) % DAY_HOURS);
         res.run_minutes   = 6'((secs / SECS_PER_MIN) % SECS_PER_MIN);
         res.run_seconds   = 6'(secs % SECS_PER_MIN);
      end
      return res;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Track config writes, predict accepted items, compare accepted results
   always @(posedge clock) begin : watch_track
      rsp_item_type want;
      if (reset) begin
         watch_mode = MODE_STOPPED;
         tick_total = '0;
         lap_snap   = '0;
         start_seen = 1'b0;
         lap_seen   = 1'b0;
         hold_limit = LAP_HOLD_RESET;
         blink_half = BLINK_RESET;
         expected_readings.delete();
      end else begin
         // spare indexes are dropped
         if (csr_wr_en) begin
            if (csr_index == REG_LAP_HOLD)
               hold_limit = csr_wdata[HOLD_W-1:0];
            else if (csr_index == REG_BLINK)
               blink_half = csr_wdata[BLINK_W-1:0];
         end
         if (req_valid && req_ready)
            expected_readings.push_back(advance_watch(req_item));
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("mode", want.mode, rsp_item.mode);
               check_field("red_led", want.red_led, rsp_item.red_led);
               check_field("green_led", want.green_led, rsp_item.green_led);
               check_field("shown_minutes", want.shown_minutes, rsp_item.shown_minutes);
               check_field("shown_seconds", want.shown_seconds, rsp_item.shown_seconds);
               check_field("colon_on", want.colon_on, rsp_item.colon_on);
               check_field("console_valid", want.console_valid, rsp_item.console_valid);
               check_field("run_hours", want.run_hours, rsp_item.run_hours);
               check_field("run_minutes", want.run_minutes, rsp_item.run_minutes);
               check_field("run_seconds", want.run_seconds, rsp_item.run_seconds);
            end
         end
      end
      pending <= expected_readings.size();
   end

endmodule

// ----- dv/stopwatch_with_lap_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives stopwatch items and register writes, reports the verdict.
module stopwatch_with_lap_tb;
   import sww_pkg::*;

   localparam int IDLE_LIMIT      = 400;
   localparam int DRAIN_CYCLES    = 4;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int CHUNK_ITEMS     = 40;

   // indexes past the two registers
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = CSR_IDX_W'(3);

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int take_stall  = 0;
   bit take_calm   = 1'b0;
   bit send_calm   = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stopwatch_with_lap DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lap_watch_monitor monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int wait_draw(bit calm);
      if (calm)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   // Receiver: hold ready low for a drawn number of cycles after each item
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_stall = wait_draw(1'b0);
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 39) == 0)
            take_calm = !take_calm;
         take_stall = wait_draw(take_calm);
         rsp_ready <= (take_stall == 0);
      end else if (!rsp_ready) begin
         if (take_stall > 0)
            take_stall = take_stall - 1;
         if (take_stall == 0)
            rsp_ready <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Present one item after a drawn gap and hold it until accepted
   task automatic send_item(input req_item_type it);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_calm = !send_calm;
      gap = wait_draw(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic send_levels(input logic tick, input logic start_level,
                              input logic lap_level);
      req_item_type it;
      it.tick         = tick;
      it.start_button = start_level;
      it.lap_button   = lap_level;
      send_item(it);
   endtask

   // Drop valid and wait until every expected result item has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers, then a spare index with junk that must be dropped
   task automatic set_config(input logic [HOLD_W-1:0] hold, input logic [BLINK_W-1:0] blink);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_wr_en <= 1'b1;
      csr_index <= REG_LAP_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= REG_BLINK;
      csr_wdata <= {junk[CSR_DATA_W-1:BLINK_W], blink};
      @(posedge clock);
      csr_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI;
      csr_wdata <= junk;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [HOLD_W-1:0]  hold_sel;
      logic [BLINK_W-1:0] blink_sel;
      logic               start_lvl;
      logic               lap_lvl;
      bit                 noisy;
      req_item_type       it;

      start_lvl = 1'b0;
      lap_lvl   = 1'b0;
      noisy     = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the modes at register defaults
      send_levels(1'b0, 1'b0, 1'b0);
      send_levels(1'b1, 1'b0, 1'b0);   // tick while stopped does not count
      send_levels(1'b0, 1'b0, 1'b1);   // lap while stopped clears
      send_levels(1'b0, 1'b1, 1'b0);   // start
      send_levels(1'b1, 1'b1, 1'b0);   // held start, no toggle
      send_levels(1'b1, 1'b0, 1'b0);
      send_levels(1'b1, 1'b0, 1'b1);   // lap capture with tick
      send_levels(1'b1, 1'b0, 1'b1);   // held lap
      send_levels(1'b0, 1'b0, 1'b0);
      send_levels(1'b0, 1'b0, 1'b1);   // resume from lap hold
      send_levels(1'b1, 1'b0, 1'b0);
      send_levels(1'b0, 1'b0, 1'b1);   // capture again
      send_levels(1'b0, 1'b1, 1'b0);   // start stops from lap hold
      send_levels(1'b0, 1'b0, 1'b0);
      send_levels(1'b0, 1'b1, 1'b1);   // both at once: start, then capture
      send_levels(1'b0, 1'b0, 1'b0);
      send_levels(1'b0, 1'b1, 1'b0);
      send_levels(1'b1, 1'b0, 1'b1);   // clear while stopped, tick ignored
      send_levels(1'b0, 1'b0, 1'b0);
      wait_drained();

      // Zero hold: capture with tick times out at once; zero blink
      set_config('0, '0);
      send_levels(1'b0, 1'b1, 1'b0);
      send_levels(1'b1, 1'b0, 1'b1);
      send_levels(1'b0, 1'b0, 1'b0);
      send_levels(1'b0, 1'b0, 1'b1);   // capture without tick stays in lap hold
      send_levels(1'b1, 1'b1, 1'b0);   // stop from lap hold on a tick
      send_levels(1'b1, 1'b1, 1'b1);   // held start, lap clears
      wait_drained();

      // Random phases over several register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin hold_sel = '1;             blink_sel = BLINK_W'(TICKS_PER_SECOND); end
            1: begin hold_sel = '0;             blink_sel = '1;                         end
            2: begin hold_sel = HOLD_W'(7);     blink_sel = BLINK_W'(1);                end
            3: begin hold_sel = LAP_HOLD_RESET; blink_sel = BLINK_RESET;                end
            4: begin
               hold_sel  = HOLD_W'($urandom_range(0, 40));
               blink_sel = BLINK_W'($urandom_range(0, 100));
            end
            default: begin
               hold_sel  = HOLD_W'($urandom_range(0, 300));
               blink_sel = BLINK_W'($urandom_range(0, 127));
            end
         endcase
         set_config(hold_sel, blink_sel);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % CHUNK_ITEMS == 0)
               noisy = ($urandom_range(0, 4) == 0);
            // hold off mid-phase until all result items are back
            if (p == 2 && i == ITEMS_PER_PHASE / 2)
               wait_drained();
            if (noisy) begin
               it = req_item_type'(3'($urandom_range(0, 7)));
            end else begin
               if ($urandom_range(0, 15) == 0)
                  start_lvl = !start_lvl;
               if ($urandom_range(0, 7) == 0)
                  lap_lvl = !lap_lvl;
               it.tick         = ($urandom_range(0, 7) != 0);
               it.start_button = start_lvl;
               it.lap_button   = lap_lvl;
            end
            send_item(it);
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
